// ===== rtl/aqtg_pkg.sv =====
// ----------------------------------------------------------------------------
// aqtg_pkg
// Types and constants shared by the quality tier governor and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package aqtg_pkg;

  typedef enum logic [1:0] {
    TIER_HIGH   = 2'd0,
    TIER_MEDIUM = 2'd1,
    TIER_LOW    = 2'd2
  } tier_t;

  localparam int unsigned TIME_W   = 16;
  localparam int unsigned SUM_W    = 24;
  localparam int unsigned FRAMES_W = 8;
  localparam int unsigned OVER_W   = 8;
  localparam int unsigned UNDER_W  = 10;
  localparam int unsigned ADDR_W   = 5;

  localparam logic [OVER_W-1:0]  OVER_RUN_MAX  = '1;
  localparam logic [UNDER_W-1:0] UNDER_RUN_MAX = '1;

  // register indexes, byte address is 4 * index
  localparam logic [2:0] REG_TRIGGER   = 3'd0;
  localparam logic [2:0] REG_HIGH_LIM  = 3'd1;
  localparam logic [2:0] REG_MED_LIM   = 3'd2;
  localparam logic [2:0] REG_DROP_LEN  = 3'd3;
  localparam logic [2:0] REG_RESTORE   = 3'd4;
  localparam logic [2:0] REG_BENCH_LEN = 3'd5;

  localparam logic [TIME_W-1:0]   TRIGGER_RST   = 16'd33000;
  localparam logic [TIME_W-1:0]   HIGH_LIM_RST  = 16'd16000;
  localparam logic [TIME_W-1:0]   MED_LIM_RST   = 16'd25000;
  localparam logic [OVER_W-1:0]   DROP_LEN_RST  = 8'd3;
  localparam logic [UNDER_W-1:0]  RESTORE_RST   = 10'd100;
  localparam logic [FRAMES_W-1:0] BENCH_LEN_RST = 8'd10;

endpackage

`default_nettype wire

// ===== rtl/adaptive_quality_tier_governor.sv =====
// ----------------------------------------------------------------------------
// adaptive_quality_tier_governor
// Picks a rendering quality tier from measured frame times.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one frame time per request (valid/ready). Each accepted request
//            yields exactly one result on out_* with the tier after that
//            frame and the benchmark-done flag.
//   APB    : six 32-bit registers at 4*index; write only while idle.
//            pready is tied high; reads return the register value.
// Path: the accepted frame time enters the input register, then the result
//   register is loaded together with the governor state once out_* is free,
//   so a stalled result keeps the next request in the input register.
// Throughput: one request per cycle while out_ready keeps results moving;
//   the state update, including the two 16x8 products of the benchmark
//   choice, is combinational between input register and result register.
// Reset (rst_n low, synchronous): registers return to their defaults, the
//   benchmark phase restarts, tier high, both pipeline slots empty.
// Stall: when out_ready is low the result holds; the input register then
//   holds one more request and in_ready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_quality_tier_governor (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [aqtg_pkg::TIME_W-1:0]   in_frame_time_us,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [1:0]                         out_tier,
  output logic                               out_benchmark_done,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [aqtg_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import aqtg_pkg::*;

  // configuration registers
  logic [TIME_W-1:0]   trigger_r;
  logic [TIME_W-1:0]   high_lim_r;
  logic [TIME_W-1:0]   med_lim_r;
  logic [OVER_W-1:0]   drop_len_r;
  logic [UNDER_W-1:0]  restore_len_r;
  logic [FRAMES_W-1:0] bench_len_r;

  // governor state
  logic                phase_done_r, phase_done_nxt;
  logic [SUM_W-1:0]    time_sum_r, time_sum_nxt;
  logic [FRAMES_W-1:0] frames_r, frames_nxt;
  tier_t               tier_r, tier_nxt;
  logic [OVER_W-1:0]   over_run_r, over_run_nxt;
  logic [UNDER_W-1:0]  under_run_r, under_run_nxt;

  // pipeline
  logic                in_full_r;
  logic [TIME_W-1:0]   frame_r;
  logic                out_valid_r;
  tier_t               out_tier_r;
  logic                out_done_r;
  logic                advance;

  logic                cfg_wr;
  logic [2:0]          cfg_idx;

  logic [FRAMES_W-1:0] frames_inc;
  logic [SUM_W-1:0]    sum_inc;
  logic [SUM_W-1:0]    prod_high;
  logic [SUM_W-1:0]    prod_med;
  logic [OVER_W-1:0]   over_inc;
  logic [UNDER_W-1:0]  under_inc;
  logic [TIME_W-1:0]   restore_lim;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_r     <= TRIGGER_RST;
      high_lim_r    <= HIGH_LIM_RST;
      med_lim_r     <= MED_LIM_RST;
      drop_len_r    <= DROP_LEN_RST;
      restore_len_r <= RESTORE_RST;
      bench_len_r   <= BENCH_LEN_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TRIGGER:   trigger_r     <= pwdata[TIME_W-1:0];
        REG_HIGH_LIM:  high_lim_r    <= pwdata[TIME_W-1:0];
        REG_MED_LIM:   med_lim_r     <= pwdata[TIME_W-1:0];
        REG_DROP_LEN:  drop_len_r    <= pwdata[OVER_W-1:0];
        REG_RESTORE:   restore_len_r <= pwdata[UNDER_W-1:0];
        REG_BENCH_LEN: bench_len_r   <= pwdata[FRAMES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_TRIGGER:   prdata = {16'd0, trigger_r};
      REG_HIGH_LIM:  prdata = {16'd0, high_lim_r};
      REG_MED_LIM:   prdata = {16'd0, med_lim_r};
      REG_DROP_LEN:  prdata = {24'd0, drop_len_r};
      REG_RESTORE:   prdata = {22'd0, restore_len_r};
      REG_BENCH_LEN: prdata = {24'd0, bench_len_r};
      default:       prdata = 32'd0;
    endcase
  end

  // handshake
  assign advance  = in_full_r & (~out_valid_r | out_ready);
  assign in_ready = ~in_full_r | advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full_r <= 1'b1;
    end else if (advance) begin
      in_full_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      frame_r <= in_frame_time_us;
    end
  end

  // benchmark arithmetic
  assign frames_inc = frames_r + 8'd1;
  assign sum_inc    = time_sum_r + {8'd0, frame_r};
  assign prod_high  = {8'd0, high_lim_r} * {16'd0, frames_inc};
  assign prod_med   = {8'd0, med_lim_r} * {16'd0, frames_inc};

  // throttle arithmetic
  assign over_inc  = (over_run_r == OVER_RUN_MAX) ? over_run_r : over_run_r + 8'd1;
  assign under_inc = (under_run_r == UNDER_RUN_MAX) ? under_run_r : under_run_r + 10'd1;

  always_comb begin
    case (tier_r)
      TIER_HIGH:   restore_lim = trigger_r;
      TIER_MEDIUM: restore_lim = high_lim_r;
      default:     restore_lim = med_lim_r;
    endcase
  end

  always_comb begin
    phase_done_nxt = phase_done_r;
    time_sum_nxt   = time_sum_r;
    frames_nxt     = frames_r;
    tier_nxt       = tier_r;
    over_run_nxt   = over_run_r;
    under_run_nxt  = under_run_r;
    if (!phase_done_r) begin
      frames_nxt   = frames_inc;
      time_sum_nxt = sum_inc;
      if (frames_inc >= bench_len_r) begin
        // compare sum against limit * n instead of dividing
        if (sum_inc < prod_high) begin
          tier_nxt = TIER_HIGH;
        end else if (sum_inc < prod_med) begin
          tier_nxt = TIER_MEDIUM;
        end else begin
          tier_nxt = TIER_LOW;
        end
        phase_done_nxt = 1'b1;
        over_run_nxt   = '0;
        under_run_nxt  = '0;
      end
    end else if (frame_r > trigger_r) begin
      over_run_nxt  = over_inc;
      under_run_nxt = '0;
      if (over_inc >= drop_len_r) begin
        case (tier_r)
          TIER_HIGH: begin
            tier_nxt     = TIER_MEDIUM;
            over_run_nxt = '0;
          end
          TIER_MEDIUM: begin
            tier_nxt     = TIER_LOW;
            over_run_nxt = '0;
          end
          default: ;
        endcase
      end
    end else if (frame_r < restore_lim) begin
      under_run_nxt = under_inc;
      over_run_nxt  = '0;
      if (under_inc >= restore_len_r) begin
        case (tier_r)
          TIER_HIGH: ;
          TIER_MEDIUM: begin
            tier_nxt      = TIER_HIGH;
            under_run_nxt = '0;
          end
          default: begin
            tier_nxt      = TIER_MEDIUM;
            under_run_nxt = '0;
          end
        endcase
      end
    end else begin
      over_run_nxt  = '0;
      under_run_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_done_r <= 1'b0;
      time_sum_r   <= '0;
      frames_r     <= '0;
      tier_r       <= TIER_HIGH;
      over_run_r   <= '0;
      under_run_r  <= '0;
    end else if (advance) begin
      phase_done_r <= phase_done_nxt;
      time_sum_r   <= time_sum_nxt;
      frames_r     <= frames_nxt;
      tier_r       <= tier_nxt;
      over_run_r   <= over_run_nxt;
      under_run_r  <= under_run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_tier_r <= tier_nxt;
      out_done_r <= phase_done_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_tier           = out_tier_r;
  assign out_benchmark_done = out_done_r;

endmodule

`default_nettype wire

// ===== rtl/aqtg_checker.sv =====
// ----------------------------------------------------------------------------
// aqtg_checker
// Port-level checks for the quality tier governor, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module aqtg_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_tier,
  input wire logic       out_benchmark_done,
  input wire logic       pready
);
  import aqtg_pkg::*;

  logic       done_seen_r;
  logic [1:0] last_tier_r;

  // track the last delivered result and whether the benchmark has finished
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_seen_r <= 1'b0;
      last_tier_r <= TIER_HIGH;
    end else if (out_valid && out_ready) begin
      done_seen_r <= done_seen_r | out_benchmark_done;
      last_tier_r <= out_tier;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tier)
      && $stable(out_benchmark_done))
    else $error("result changed while stalled");

  a_tier_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_tier == TIER_HIGH || out_tier == TIER_MEDIUM
      || out_tier == TIER_LOW)
    else $error("illegal tier code");

  a_bench_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_benchmark_done |-> out_tier == TIER_HIGH && !done_seen_r)
    else $error("tier left high during benchmark, or benchmark restarted");

  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && done_seen_r |->
      !(out_tier == TIER_HIGH && last_tier_r == TIER_LOW) &&
      !(out_tier == TIER_LOW && last_tier_r == TIER_HIGH))
    else $error("tier moved more than one step in throttle phase");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready dropped");

endmodule

bind adaptive_quality_tier_governor aqtg_checker u_aqtg_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_tier           (out_tier),
  .out_benchmark_done (out_benchmark_done),
  .pready             (pready)
);

`default_nettype wire
